// File: src/wpe_pkg.sv
`timescale 1ns / 1ps

package wpe_pkg;

  // Field and register widths.
  localparam int SAMPLE_W   = 16;
  localparam int POWER_W    = 41;
  localparam int BS_W       = 7;
  localparam int HOP_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int ROM_W      = 32;

  // Defaults for the top-level parameters.
  localparam int WINDOW_SIZE_DEF = 1024;
  localparam int MAX_OVERLAP_DEF = 32;
  localparam int MAX_BLOCK_DEF   = 64;

  // Register reset values.
  localparam logic [BS_W-1:0]  BLOCK_SIZE_RST = 7'd64;
  localparam logic [HOP_W-1:0] HOP_RST        = 11'd512;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BLOCK_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HOP        = 2'd1;

  localparam logic [POWER_W-1:0] SUM_MAX = {POWER_W{1'b1}};

  // Pi in unsigned Q2.30 and the divisors (2k)(2k+1) of the sine series.
  localparam logic [63:0] PI_Q30 = 64'hC90F_DAA2;
  localparam logic [63:0] SER_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                          64'd110, 64'd156, 64'd210};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic square;
    logic issue;
    logic blk_end;
    logic emit_rd;
    logic emit_ld;
    logic sh_start;
    logic sh_step;
    logic sh_stop;
  } wpe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic issue_done;
    logic pipe_busy;
    logic blk_last;
    logic phase_wrap;
    logic out_full;
    logic sh_more;
  } wpe_status_t;

  // Truncated Taylor series for the sine in Q2.30, used only to build the window table.
  function automatic logic [63:0] sine_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int k = 1; k <= 7; k++) begin
      term = (term * x2) >> 30;
      term = term / SER_DIV[k-1];
      if ((k % 2) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    if (sum > (64'd1 << 30)) begin
      sum = 64'd1 << 30;
    end
    return sum;
  endfunction

endpackage

// File: src/wpe_if.sv
`timescale 1ns / 1ps

// Sample input channel.
interface wpe_sample_if import wpe_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// Power result channel.
interface wpe_power_if import wpe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [POWER_W-1:0] power;

  modport source (output valid, output power, input ready);
  modport sink (input valid, input power, output ready);
endinterface

// Configuration write channel.
interface wpe_cfg_if import wpe_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/wpe_ctrl.sv
`timescale 1ns / 1ps

module wpe_ctrl import wpe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  wpe_status_t status_i,
  output wpe_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ACC,
    S_DRAIN,
    S_EMIT_WAIT,
    S_EMIT_LD,
    S_SHIFT
  } state_e;

  state_e state_q, state_d;
  logic   rdy_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && rdy_q) begin
          cmd_o.start = 1'b1;
          state_d     = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        if (status_i.issue_done) begin
          state_d = S_DRAIN;
        end else begin
          cmd_o.issue = 1'b1;
        end
      end
      S_DRAIN: begin
        if (!status_i.pipe_busy) begin
          cmd_o.blk_end = 1'b1;
          if (status_i.blk_last && status_i.phase_wrap) begin
            state_d = S_EMIT_WAIT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_EMIT_WAIT: begin
        if (!status_i.out_full) begin
          cmd_o.emit_rd = 1'b1;
          state_d       = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        cmd_o.emit_ld  = 1'b1;
        cmd_o.sh_start = 1'b1;
        state_d        = S_SHIFT;
      end
      S_SHIFT: begin
        if (status_i.sh_more) begin
          cmd_o.sh_step = 1'b1;
        end else begin
          cmd_o.sh_stop = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rdy_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      rdy_q   <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = rdy_q;

endmodule

// File: src/wpe_datapath.sv
`timescale 1ns / 1ps

module wpe_datapath import wpe_pkg::*; #(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
  parameter int MAX_OVERLAP = MAX_OVERLAP_DEF,
  parameter int MAX_BLOCK   = MAX_BLOCK_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  wpe_cmd_t                   cmd_i,
  output wpe_status_t                status_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [POWER_W-1:0]         power_o
);

  localparam int SA_W   = $clog2(MAX_OVERLAP);
  localparam int K_W    = $clog2(MAX_OVERLAP + 1);
  localparam int IDX_W  = $clog2(WINDOW_SIZE);
  localparam int NB_W   = $clog2(MAX_BLOCK + 1);
  localparam int POS_W  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int CW     = (NB_W > BS_W) ? NB_W : BS_W;
  localparam int PH_W   = $clog2(WINDOW_SIZE + (1 << HOP_W) + MAX_BLOCK) + 1;
  localparam int SH_W   = $clog2(WINDOW_SIZE + (1 << HOP_W));
  localparam int SQ_W   = 2 * SAMPLE_W - 1;
  localparam int PROD_W = SQ_W + ROM_W;
  localparam int RND_SH = 22;
  localparam int ADD_W  = PROD_W - RND_SH;

  localparam logic [PROD_W-1:0] RND    = PROD_W'(1) << (RND_SH - 1);
  localparam logic [63:0]       WIN_N  = 64'(WINDOW_SIZE);
  localparam logic [63:0]       WIN_DEN = WIN_N << 27;

  // Hann window entry i, scaled by 1/N, in units of 2^-33.
  function automatic logic [ROM_W-1:0] win_entry(input int unsigned i);
    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] s;
    logic [63:0] e;
    m = (64'(i) <= WIN_N - 64'(i)) ? 64'(i) : WIN_N - 64'(i);
    a = (PI_Q30 * m + (WIN_N >> 1)) / WIN_N;
    s = sine_q30(a);
    e = (s * s + (WIN_N << 26)) / WIN_DEN;
    return e[ROM_W-1:0];
  endfunction

  logic [ROM_W-1:0] rom [WINDOW_SIZE];

  for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_rom
    localparam logic [ROM_W-1:0] Entry = win_entry(g);
    assign rom[g] = Entry;
  end

  // Configuration registers.
  logic [BS_W-1:0]  block_q;
  logic [HOP_W-1:0] hop_q;

  // Control counters.
  logic signed [PH_W-1:0] phase_q, base_q;
  logic [POS_W-1:0]       pos_q;
  logic [K_W-1:0]         k_q, i_q;
  logic [SH_W-1:0]        acc_q;
  logic [MAX_OVERLAP-1:0] valid_q;

  // Accumulation pipeline.
  logic                   b_vld_q, b_inw_q, c_vld_q, d_vld_q;
  logic [SA_W-1:0]        b_k_q, c_k_q, d_k_q;
  logic [SAMPLE_W-1:0]    mag_q;
  logic [SQ_W-1:0]        sq_q;
  logic [ROM_W-1:0]       rom_q;
  logic [PROD_W-1:0]      prod_q;
  logic [ADD_W-1:0]       add_q;
  logic [POWER_W-1:0]     c_base_q, d_base_q;

  // Slot memory with read port, valid bits and shift write stage.
  logic [POWER_W-1:0]     mem [MAX_OVERLAP];
  logic [POWER_W-1:0]     rd_q;
  logic                   rd_vld_q;
  logic                   sh_wr_q;
  logic [SA_W-1:0]        sh_wa_q;

  logic                   out_vld_q;
  logic [POWER_W-1:0]     power_q;

  logic [CW-1:0]          bs_ext;
  logic [NB_W-1:0]        n_eff;
  logic signed [PH_W-1:0] hop_s, n_s, pos_s, idx_s, ph_sub;
  logic                   inw;
  logic [IDX_W-1:0]       idx_lo;
  logic [K_W-1:0]         i_inc;
  logic [SA_W-1:0]        rd_addr;
  logic [2*SAMPLE_W-1:0]  sq_full;
  logic [PROD_W-1:0]      prod_full, rnd_sum;
  logic [POWER_W:0]       acc_sum;
  logic [POWER_W-1:0]     acc_wd, wr_data;
  logic [SA_W-1:0]        wr_addr;
  logic                   wr_en, blk_last;
  logic [SAMPLE_W-1:0]    mag_d;

  // Block size of zero counts as one, and anything above the maximum as the maximum.
  assign bs_ext = CW'(block_q);
  always_comb begin
    if (block_q == '0) begin
      n_eff = NB_W'(1);
    end else if (bs_ext > CW'(MAX_BLOCK)) begin
      n_eff = NB_W'(MAX_BLOCK);
    end else begin
      n_eff = NB_W'(bs_ext);
    end
  end

  assign hop_s  = $signed(PH_W'(hop_q));
  assign n_s    = $signed(PH_W'(n_eff));
  assign pos_s  = $signed(PH_W'(pos_q));
  assign idx_s  = base_q + n_s - pos_s - $signed(PH_W'(1));
  assign inw    = !idx_s[PH_W-1] && (idx_s < $signed(PH_W'(WINDOW_SIZE)));
  assign idx_lo = idx_s[IDX_W-1:0];
  assign ph_sub = phase_q - n_s;
  assign i_inc  = i_q + K_W'(1);

  assign blk_last = ((NB_W + 1)'(pos_q) + (NB_W + 1)'(1)) >= (NB_W + 1)'(n_eff);

  assign status_o.issue_done = (k_q == K_W'(MAX_OVERLAP)) ||
                               (base_q >= $signed(PH_W'(WINDOW_SIZE)));
  assign status_o.pipe_busy  = b_vld_q || c_vld_q || d_vld_q;
  assign status_o.blk_last   = blk_last;
  assign status_o.phase_wrap = ph_sub[PH_W-1];
  assign status_o.out_full   = out_vld_q;
  assign status_o.sh_more    = (i_inc < K_W'(MAX_OVERLAP)) && (acc_q < SH_W'(WINDOW_SIZE));

  always_comb begin
    rd_addr = k_q[SA_W-1:0];
    if (cmd_i.emit_rd) begin
      rd_addr = '0;
    end else if (cmd_i.sh_step) begin
      rd_addr = i_inc[SA_W-1:0];
    end
  end

  assign mag_d     = sample_i[SAMPLE_W-1] ? $unsigned(-sample_i) : $unsigned(sample_i);
  assign sq_full   = mag_q * mag_q;
  assign prod_full = PROD_W'(sq_q) * PROD_W'(rom_q);
  assign rnd_sum   = prod_q + RND;
  assign acc_sum   = (POWER_W + 1)'(d_base_q) + (POWER_W + 1)'(add_q);
  assign acc_wd    = acc_sum[POWER_W] ? SUM_MAX : acc_sum[POWER_W-1:0];

  assign wr_en   = d_vld_q || sh_wr_q;
  assign wr_addr = d_vld_q ? d_k_q : sh_wa_q;
  assign wr_data = d_vld_q ? acc_wd : rd_q;

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_q   <= BLOCK_SIZE_RST;
      hop_q     <= HOP_RST;
      phase_q   <= '0;
      base_q    <= '0;
      pos_q     <= '0;
      k_q       <= '0;
      i_q       <= '0;
      acc_q     <= '0;
      valid_q   <= '0;
      rd_vld_q  <= 1'b0;
      b_vld_q   <= 1'b0;
      b_inw_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      sh_wr_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_IDX_BLOCK_SIZE) begin
          block_q <= cfg_data_i[BS_W-1:0];
        end else if (cfg_idx_i == CFG_IDX_HOP) begin
          hop_q <= cfg_data_i[HOP_W-1:0];
        end
      end

      rd_vld_q <= valid_q[rd_addr];
      b_vld_q  <= cmd_i.issue;
      b_inw_q  <= inw;
      c_vld_q  <= b_vld_q && b_inw_q;
      d_vld_q  <= c_vld_q;
      sh_wr_q  <= cmd_i.sh_step;

      if (cmd_i.start) begin
        k_q    <= '0;
        base_q <= phase_q;
      end else if (cmd_i.issue) begin
        k_q    <= k_q + K_W'(1);
        base_q <= base_q + hop_s;
      end

      if (cmd_i.blk_end) begin
        if (blk_last) begin
          pos_q   <= '0;
          phase_q <= ph_sub;
          // Clear the slot just past the active ones, if there is one.
          if (k_q < K_W'(MAX_OVERLAP)) begin
            valid_q[k_q[SA_W-1:0]] <= 1'b0;
          end
        end else begin
          pos_q <= pos_q + POS_W'(1);
        end
      end

      if (cmd_i.sh_start) begin
        i_q   <= '0;
        acc_q <= SH_W'(hop_q);
      end else if (cmd_i.sh_step) begin
        i_q   <= i_inc;
        acc_q <= acc_q + SH_W'(hop_q);
      end

      if (d_vld_q) begin
        valid_q[d_k_q] <= 1'b1;
      end
      if (sh_wr_q) begin
        valid_q[sh_wa_q] <= rd_vld_q;
      end
      if (cmd_i.sh_stop) begin
        valid_q[i_q[SA_W-1:0]] <= 1'b0;
        phase_q <= hop_s - n_s;
      end

      if (cmd_i.emit_ld) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mag_q <= mag_d;
    end
    if (cmd_i.square) begin
      sq_q <= sq_full[SQ_W-1:0];
    end
    rom_q    <= rom[idx_lo];
    b_k_q    <= k_q[SA_W-1:0];
    prod_q   <= prod_full;
    c_base_q <= rd_vld_q ? rd_q : '0;
    c_k_q    <= b_k_q;
    add_q    <= rnd_sum[PROD_W-1:RND_SH];
    d_base_q <= c_base_q;
    d_k_q    <= c_k_q;
    sh_wa_q  <= i_q[SA_W-1:0];
    if (cmd_i.emit_ld) begin
      power_q <= rd_vld_q ? rd_q : '0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign power_o     = power_q;

endmodule

// File: src/windowed_power_envelope.sv
`timescale 1ns / 1ps

// Channel    Dir  Payload                        Transfer when
// sample_i   in   sample, 16-bit signed Q1.15    sample_i.valid && sample_i.ready
// power_o    out  power, 41-bit unsigned 2^-41   power_o.valid && power_o.ready
// cfg_i      in   index 2 bits, data 11 bits     cfg_i.valid && cfg_i.ready
//
// A sample's time from its transfer to the earliest next transfer grows with A, the
// number of active slots; the slots are updated one per cycle through a single
// multiplier and the one read and one write port of the slot memory.
// A sample that emits a result then waits for the output register to be empty and
// makes the slot moves, which go through the same memory ports one slot per cycle.
// Reset clears all slot sums at once through per-slot valid bits and loads the
// register defaults. A stalled result sits in the output register; samples keep
// flowing until the next emitting block end, which waits until that register is empty.

module windowed_power_envelope import wpe_pkg::*; #(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
  parameter int MAX_OVERLAP = MAX_OVERLAP_DEF,
  parameter int MAX_BLOCK   = MAX_BLOCK_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  wpe_sample_if.sink   sample_i,
  wpe_power_if.source  power_o,
  wpe_cfg_if.sink      cfg_i
);

  wpe_cmd_t    cmd;
  wpe_status_t status;
  logic        in_ready;

  // Cfg is always ready; users must send writes only while idle; nothing enforces it.
  assign cfg_i.ready    = 1'b1;
  assign sample_i.ready = in_ready;

  // The controller sequences one sample: square, walk the active slots, then
  // do the block-end bookkeeping and, at a block end with a phase wrap, emit and shift the slots.
  wpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the window table, the slot memory, the multiply and
  // accumulate pipeline, the counters and the output register.
  wpe_datapath #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .MAX_OVERLAP (MAX_OVERLAP),
    .MAX_BLOCK   (MAX_BLOCK)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_i.sample),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (power_o.valid),
    .out_ready_i (power_o.ready),
    .power_o     (power_o.power)
  );

endmodule

// File: src/wpe_checker.sv
`timescale 1ns / 1ps

module wpe_checker import wpe_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [POWER_W-1:0] power_i,
  input logic               cfg_ready_i
);

  // A waiting result holds its value until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(power_i))
    else $error("power result changed or dropped while stalled");

  // Ready drops after a transfer, since the sample is still being worked on.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("sample channel ready right after a transfer");

  // A new result is only produced while a sample is being worked on.
  a_result_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !in_ready_i)
    else $error("result appeared while the block was idle");

  // Configuration writes are never refused.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration channel not ready");

endmodule

bind windowed_power_envelope wpe_checker u_wpe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (power_o.valid),
  .out_ready_i (power_o.ready),
  .power_i     (power_o.power),
  .cfg_ready_i (cfg_i.ready)
);
